[src/tcf_pkg.sv]
// ----------------------------------------------------------------------------
// tcf_pkg: shared types and constants for the telnet receive command filter
// Telnet byte codes, option numbers and the reply request that the parser
// hands to the emitter.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam logic [7:0] B_IAC  = 8'hff;
  localparam logic [7:0] B_DONT = 8'hfe;
  localparam logic [7:0] B_DO   = 8'hfd;
  localparam logic [7:0] B_WONT = 8'hfc;
  localparam logic [7:0] B_WILL = 8'hfb;
  localparam logic [7:0] B_SB   = 8'hfa;
  localparam logic [7:0] B_AYT  = 8'hf6;
  localparam logic [7:0] B_SE   = 8'hf0;
  localparam logic [7:0] B_CR   = 8'h0d;
  localparam logic [7:0] B_LF   = 8'h0a;
  localparam logic [7:0] B_NUL  = 8'h00;

  localparam logic [7:0] OPT_BINARY = 8'h00;
  localparam logic [7:0] OPT_ECHO   = 8'h01;
  localparam logic [7:0] OPT_SGA    = 8'h03;

  // Longest burst one received byte can cause.
  localparam int unsigned MaxBurst = 9;
  localparam int unsigned BurstW   = $clog2(MaxBurst + 1);

  typedef enum logic [1:0] {
    MODE_DATA,   // one byte to the terminal
    MODE_AYT,    // "\r\n[Yes]\r\n" to the network
    MODE_REPLY   // option reply and/or announcement to the network
  } mode_e;

  // Burst request from parser to emitter.
  typedef struct packed {
    logic       vld;
    mode_e      mode;
    logic       has_cmd;  // three-byte IAC verb option reply
    logic       has_ann;  // IAC WILL BINARY, IAC WILL ECHO
    logic [7:0] data;     // data byte or option code
    logic [7:0] verb;
  } burst_t;

endpackage

[src/tcf_parser.sv]
// ----------------------------------------------------------------------------
// tcf_parser: telnet command parser
// Tracks the command state and the one-time announcement flag, and turns
// each received byte into a burst request for the emitter.
// ----------------------------------------------------------------------------
module tcf_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  output tcf_pkg::burst_t burst_o
);
  import tcf_pkg::*;

  localparam logic [3:0] ST_DATA = 4'd0;
  localparam logic [3:0] ST_IAC  = 4'd1;
  localparam logic [3:0] ST_CR   = 4'd2;
  localparam logic [3:0] ST_SB   = 4'd3;
  localparam logic [3:0] ST_SE   = 4'd4;
  localparam logic [3:0] ST_WILL = 4'd5;
  localparam logic [3:0] ST_WONT = 4'd6;
  localparam logic [3:0] ST_DO   = 4'd7;
  localparam logic [3:0] ST_DONT = 4'd8;

  logic [3:0] state_q, state_d;
  logic       announced_q, announced_d;
  logic       supported;
  logic       plain_data;
  burst_t     burst;

  always_comb begin
    supported   = rx_byte_i inside {OPT_BINARY, OPT_ECHO, OPT_SGA};
    state_d     = state_q;
    announced_d = announced_q;
    plain_data  = 1'b0;
    burst       = '0;
    burst.mode  = MODE_DATA;
    burst.data  = rx_byte_i;
    burst.verb  = B_IAC;

    case (state_q)
      ST_DATA: plain_data = 1'b1;
      ST_CR: begin
        state_d    = ST_DATA;
        plain_data = (rx_byte_i != B_NUL) && (rx_byte_i != B_LF);
      end
      ST_IAC: begin
        state_d = ST_DATA;
        case (rx_byte_i)
          B_SB:   state_d = ST_SB;
          B_WILL: state_d = ST_WILL;
          B_WONT: state_d = ST_WONT;
          B_DO:   state_d = ST_DO;
          B_DONT: state_d = ST_DONT;
          B_AYT: begin
            burst.vld  = 1'b1;
            burst.mode = MODE_AYT;
          end
          B_IAC:  burst.vld = 1'b1;  // escaped 255 to the terminal
          default: ;
        endcase
      end
      ST_SB: begin
        if (rx_byte_i == B_IAC) state_d = ST_SE;
      end
      ST_SE: state_d = (rx_byte_i == B_SE) ? ST_DATA : ST_SB;
      ST_WILL, ST_DO: begin
        state_d       = ST_DATA;
        announced_d   = 1'b1;
        burst.vld     = 1'b1;
        burst.mode    = MODE_REPLY;
        burst.has_cmd = 1'b1;
        burst.has_ann = !announced_q;
        if (state_q == ST_WILL) burst.verb = supported ? B_DO : B_DONT;
        else                    burst.verb = supported ? B_WILL : B_WONT;
      end
      ST_WONT, ST_DONT: begin
        state_d       = ST_DATA;
        announced_d   = 1'b1;
        burst.vld     = !announced_q;
        burst.mode    = MODE_REPLY;
        burst.has_ann = !announced_q;
      end
      default: ;  // unreachable codes: hold state, drop byte
    endcase

    if (plain_data) begin
      if (rx_byte_i == B_IAC) begin
        state_d = ST_IAC;
      end else begin
        state_d   = (rx_byte_i == B_CR) ? ST_CR : ST_DATA;
        burst.vld = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_DATA;
      announced_q <= 1'b0;
    end else if (accept_i) begin
      state_q     <= state_d;
      announced_q <= announced_d;
    end
  end

  assign burst_o = burst;

endmodule

[src/tcf_emitter.sv]
// ----------------------------------------------------------------------------
// tcf_emitter: result sequencer
// Holds one burst request and steps through its bytes, one per accepted
// result, marking the final byte of the burst.
// ----------------------------------------------------------------------------
module tcf_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  tcf_pkg::burst_t burst_i,
  output logic            ready_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            to_network_o,
  output logic            last_o
);
  import tcf_pkg::*;

  localparam logic [7:0] AytReply [MaxBurst] = '{
    8'h0d, 8'h0a, 8'h5b, 8'h59, 8'h65, 8'h73, 8'h5d, 8'h0d, 8'h0a
  };
  localparam logic [BurstW-1:0] CmdLen = BurstW'(3);
  localparam logic [BurstW-1:0] AnnLen = BurstW'(6);

  logic              busy_q;
  logic [BurstW-1:0] idx_q, len_q, len_d;
  mode_e             mode_q;
  logic              has_cmd_q;
  logic [7:0]        data_q, verb_q;
  logic              out_acc, done;
  logic [BurstW-1:0] ann_pos;
  logic [7:0]        byte_sel;

  always_comb begin
    case (burst_i.mode)
      MODE_DATA: len_d = BurstW'(1);
      MODE_AYT:  len_d = BurstW'(MaxBurst);
      default:   len_d = (burst_i.has_cmd ? CmdLen : '0) + (burst_i.has_ann ? AnnLen : '0);
    endcase
  end

  assign out_acc = busy_q && !out_stall_i;
  assign last_o  = (idx_q == len_q - BurstW'(1));
  assign done    = out_acc && last_o;
  assign ready_o = !busy_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (done) begin
      busy_q <= 1'b0;
    end else if (out_acc) begin
      idx_q <= idx_q + BurstW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      mode_q    <= burst_i.mode;
      has_cmd_q <= burst_i.has_cmd;
      data_q    <= burst_i.data;
      verb_q    <= burst_i.verb;
      len_q     <= len_d;
    end
  end

  // Announcement bytes follow the option reply when both are due.
  assign ann_pos = has_cmd_q ? idx_q - CmdLen : idx_q;

  always_comb begin
    byte_sel = B_IAC;
    if (has_cmd_q && idx_q < CmdLen) begin
      case (idx_q)
        BurstW'(1): byte_sel = verb_q;
        BurstW'(2): byte_sel = data_q;
        default:    byte_sel = B_IAC;
      endcase
    end else begin
      case (ann_pos)
        BurstW'(1), BurstW'(4): byte_sel = B_WILL;
        BurstW'(2):             byte_sel = OPT_BINARY;
        BurstW'(5):             byte_sel = OPT_ECHO;
        default:                byte_sel = B_IAC;
      endcase
    end
  end

  always_comb begin
    case (mode_q)
      MODE_DATA: begin
        out_byte_o   = data_q;
        to_network_o = 1'b0;
      end
      MODE_AYT: begin
        out_byte_o   = (idx_q < BurstW'(MaxBurst)) ? AytReply[idx_q] : B_CR;
        to_network_o = 1'b1;
      end
      default: begin
        out_byte_o   = byte_sel;
        to_network_o = 1'b1;
      end
    endcase
  end

  assign out_valid_o = busy_q;

endmodule

[src/telnet_rx_command_filter.sv]
// ----------------------------------------------------------------------------
// telnet_rx_command_filter: telnet receive command filter
// Splits received telnet bytes between the terminal and network replies.
// ----------------------------------------------------------------------------
// The first result is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte causes at most one result and the
// output is not stalled; a byte that causes a reply burst holds off the next byte
// until the last result is taken, as the single result register steps through the burst.
// Reset: asynchronous, active low; returns to the data state with the option
// announcement still pending and no result held.
module telnet_rx_command_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       to_network_o,
  output logic       last_o
);
  import tcf_pkg::*;

  logic   in_acc;
  logic   ready;
  burst_t burst;

  assign in_stall_o = !ready;
  assign in_acc     = in_valid_i && ready;

  tcf_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .rx_byte_i (rx_byte_i),
    .burst_o   (burst)
  );

  tcf_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc && burst.vld),
    .burst_i      (burst),
    .ready_o      (ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .to_network_o (to_network_o),
    .last_o       (last_o)
  );

endmodule

[src/tcf_checker.sv]
// ----------------------------------------------------------------------------
// tcf_checker: port-level checks for the telnet receive command filter
// Watches the top-level ports for burst and handshake consistency.
// ----------------------------------------------------------------------------
module tcf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       to_network_o,
  input logic       last_o
);

  // A result can only appear after a request was taken.
  a_rise_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an accepted request");

  // Input is held off only while a result is pending.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // Terminal data is always a single result.
  a_terminal_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !to_network_o) |-> last_o)
    else $error("terminal byte not marked last");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(to_network_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind telnet_rx_command_filter tcf_checker u_tcf_checker (.*);
